// File: rtl/sjf_pkg.sv
// ============================================================================
// sjf_pkg
// Shared types and constants for the shortest-job-first scheduler.
// ============================================================================
`default_nettype none

package sjf_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ARR_W     = 16;
  localparam int BUR_W     = 16;
  localparam int TIME_W    = 21;
  localparam int NUM_W     = 5;
  localparam int WORD_W    = ARR_W + BUR_W;

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [BUR_W-1:0] burst_time;
    logic             last_process;
  } job_t;

  typedef struct packed {
    logic              segment_idle;
    logic [NUM_W-1:0]  process_number;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              last_segment;
  } segment_t;

  // One table entry on its way from the memory into the selector
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             done;
    logic [IDX_W-1:0] idx;
  } scan_elem_t;

  // Running outcome of a table walk
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [ARR_W-1:0] min_arrival;
  } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/sjf_ram.sv
// ============================================================================
// sjf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
`default_nettype none

module sjf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/sjf_scan.sv
// ============================================================================
// sjf_scan
// Walk selector: folds one table entry per cycle into the best ready job
// and the earliest pending arrival.
// ============================================================================
`default_nettype none

module sjf_scan (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sjf_pkg::scan_elem_t         elem,
  input  wire logic [sjf_pkg::WORD_W-1:0]  word,
  input  wire logic [sjf_pkg::TIME_W-1:0]  cur_time,
  output sjf_pkg::scan_res_t               res
);

  logic [sjf_pkg::ARR_W-1:0] arr;
  logic [sjf_pkg::BUR_W-1:0] bur;
  logic                      base_found;
  logic                      base_have;
  logic                      ready;
  logic                      better;
  logic                      have;

  assign arr = word[sjf_pkg::WORD_W-1:sjf_pkg::BUR_W];
  assign bur = word[sjf_pkg::BUR_W-1:0];

  // The first entry of a walk restarts both trackers
  assign base_found = res.found & ~elem.first;
  assign base_have  = have & ~elem.first;

  assign ready  = ~elem.done && (sjf_pkg::TIME_W'(arr) <= cur_time);
  assign better = ~base_found || (bur < res.burst) ||
                  ((bur == res.burst) && (arr < res.arrival));

  always_ff @(posedge clk) begin
    if (rst) begin
      res.found <= 1'b0;
      have      <= 1'b0;
    end else if (elem.valid) begin
      res.found <= base_found;
      have      <= base_have;
      if (ready && better) begin
        res.found   <= 1'b1;
        res.idx     <= elem.idx;
        res.arrival <= arr;
        res.burst   <= bur;
      end
      if (~elem.done && (~base_have || arr < res.min_arrival)) begin
        have            <= 1'b1;
        res.min_arrival <= arr;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sjf_nonpreemptive_scheduler.sv
// ============================================================================
// sjf_nonpreemptive_scheduler
// Non-preemptive shortest-job-first scheduler with a job table in RAM.
// ============================================================================
//
//   channel   handshake          word       notes
//   --------  -----------------  ---------  -------------------------------
//   job       start & !busy      job        one job per word, last starts run
//   segment   valid (1 cycle)    segment    one Gantt segment per word
//
// A job that is not the last leaves the block free for the next word. The last job starts the run:
// each decision walks the n loaded table entries through the RAM read port,
// one per cycle; a schedule has at most 2n decisions.
// Reset clears the job count, done flags and time; table contents need none.
// The receiver cannot stall: each segment shows for exactly one cycle.
// ============================================================================
`default_nettype none

module sjf_nonpreemptive_scheduler (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire sjf_pkg::job_t     job,
  output logic                   valid,
  output sjf_pkg::segment_t      segment
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]                  state;
  logic [sjf_pkg::CNT_W-1:0]   loaded;
  logic [sjf_pkg::CNT_W-1:0]   finished;
  logic [sjf_pkg::CNT_W-1:0]   ptr;
  logic [sjf_pkg::TIME_W-1:0]  cur_time;
  logic [sjf_pkg::MAX_PROCS-1:0] done_flags;
  sjf_pkg::scan_elem_t         elem;
  sjf_pkg::scan_res_t          res;
  logic [sjf_pkg::WORD_W-1:0]  rdata;

  logic                        accept;
  logic                        store_we;
  logic [sjf_pkg::TIME_W-1:0]  end_run;
  logic [sjf_pkg::TIME_W-1:0]  min_arr;
  logic                        final_job;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign store_we = accept && (loaded < sjf_pkg::CNT_W'(sjf_pkg::MAX_PROCS));

  assign end_run   = cur_time + sjf_pkg::TIME_W'(res.burst);
  assign min_arr   = sjf_pkg::TIME_W'(res.min_arrival);
  assign final_job = (finished + sjf_pkg::CNT_W'(1)) == loaded;

  sjf_ram #(
    .WIDTH (sjf_pkg::WORD_W),
    .DEPTH (sjf_pkg::MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (store_we),
    .waddr (loaded[sjf_pkg::IDX_W-1:0]),
    .wdata ({job.arrival_time, job.burst_time}),
    .raddr (ptr[sjf_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  sjf_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .elem     (elem),
    .word     (rdata),
    .cur_time (cur_time),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      loaded     <= '0;
      finished   <= '0;
      ptr        <= '0;
      cur_time   <= '0;
      done_flags <= '0;
      elem.valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      valid      <= 1'b0;
      elem.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (store_we) begin
              loaded <= loaded + sjf_pkg::CNT_W'(1);
            end
            if (job.last_process) begin
              state    <= ST_SCAN;
              ptr      <= '0;
              cur_time <= '0;
              finished <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (ptr < loaded) begin
            // issue one table read; flag and index ride along with it
            elem.valid <= 1'b1;
            elem.first <= (ptr == '0);
            elem.idx   <= ptr[sjf_pkg::IDX_W-1:0];
            elem.done  <= done_flags[ptr[sjf_pkg::IDX_W-1:0]];
            ptr        <= ptr + sjf_pkg::CNT_W'(1);
          end else if (!elem.valid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          valid <= 1'b1;
          segment.start_time <= cur_time;
          ptr <= '0;
          if (res.found) begin
            segment.segment_idle   <= 1'b0;
            segment.process_number <= sjf_pkg::NUM_W'(res.idx) + sjf_pkg::NUM_W'(1);
            segment.end_time       <= end_run;
            segment.turnaround     <= end_run - sjf_pkg::TIME_W'(res.arrival);
            segment.waiting        <= cur_time - sjf_pkg::TIME_W'(res.arrival);
            segment.last_segment   <= final_job;
            if (final_job) begin
              // schedule complete: drop back to an empty table
              state      <= ST_IDLE;
              loaded     <= '0;
              finished   <= '0;
              cur_time   <= '0;
              done_flags <= '0;
            end else begin
              state               <= ST_SCAN;
              finished            <= finished + sjf_pkg::CNT_W'(1);
              cur_time            <= end_run;
              done_flags[res.idx] <= 1'b1;
            end
          end else begin
            // nothing ready: idle until the earliest pending arrival
            segment.segment_idle   <= 1'b1;
            segment.process_number <= '0;
            segment.end_time       <= min_arr;
            segment.turnaround     <= '0;
            segment.waiting        <= '0;
            segment.last_segment   <= 1'b0;
            cur_time               <= min_arr;
            state                  <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/sjf_checker.sv
// ============================================================================
// sjf_checker
// Port-level checks for the scheduler, bound onto the top level.
// ============================================================================
`default_nettype none

module sjf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire sjf_pkg::job_t     job,
  input wire logic              valid,
  input wire sjf_pkg::segment_t segment
);

  // A plain load word leaves the block free for the next one
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !job.last_process |=> !busy)
    else $error("busy after a plain load word");

  // The closing job word starts a run
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && job.last_process |=> busy)
    else $error("run did not start after last job");

  // The final segment shows only once the block is free again
  a_last_free: assert property (@(posedge clk) disable iff (rst)
    valid && segment.last_segment |-> !busy)
    else $error("final segment while still busy");

  // Any other segment comes out mid-run
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !segment.last_segment |-> busy)
    else $error("segment outside a run");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    valid && segment.segment_idle |->
      (segment.process_number == '0) && (segment.turnaround == '0) &&
      (segment.waiting == '0))
    else $error("idle segment carries job data");

endmodule

bind sjf_nonpreemptive_scheduler sjf_checker u_sjf_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .job     (job),
  .valid   (valid),
  .segment (segment)
);

`default_nettype wire

// File: tb/sjf_segment_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// sjf_segment_checker
// Watches the job and segment channels of the scheduler, builds the expected
// Gantt chart for each job set and compares every segment word against it.
// ============================================================================

module sjf_segment_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire sjf_pkg::job_t     job,
  input  wire logic              valid,
  input  wire sjf_pkg::segment_t segment,
  output int                     errors,
  output int                     pending,
  output int                     compared,
  output int                     idle_compared
);
  import sjf_pkg::*;

  logic [ARR_W-1:0] arrival_tab [MAX_PROCS];
  logic [BUR_W-1:0] burst_tab [MAX_PROCS];
  int               jobs_loaded;
  segment_t         chart_q [$];

  initial begin
    errors        = 0;
    pending       = 0;
    compared      = 0;
    idle_compared = 0;
    jobs_loaded   = 0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      flag_error($sformatf("segment %0d %s got %0d want %0d", compared, name, got, want));
  endtask

  // Walk the loaded set from tick 0 and queue every segment it produces
  task automatic build_chart();
    bit                done [MAX_PROCS];
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] fin;
    logic [TIME_W-1:0] tat;
    logic [ARR_W-1:0]  next_arr;
    int                best;
    int                finished;
    bit                have;
    segment_t          seg;
    for (int i = 0; i < MAX_PROCS; i++) done[i] = 1'b0;
    now      = '0;
    finished = 0;
    while (finished < jobs_loaded) begin
      best = -1;
      for (int i = 0; i < jobs_loaded; i++) begin
        if (done[i] || TIME_W'(arrival_tab[i]) > now) continue;
        if (best < 0 || burst_tab[i] < burst_tab[best] ||
            (burst_tab[i] == burst_tab[best] && arrival_tab[i] < arrival_tab[best]))
          best = i;
      end
      seg = '0;
      if (best < 0) begin
        // nothing has arrived: idle until the earliest pending arrival
        have     = 1'b0;
        next_arr = '0;
        for (int i = 0; i < jobs_loaded; i++) begin
          if (!done[i] && (!have || arrival_tab[i] < next_arr)) begin
            next_arr = arrival_tab[i];
            have     = 1'b1;
          end
        end
        seg.segment_idle = 1'b1;
        seg.start_time   = now;
        seg.end_time     = TIME_W'(next_arr);
        now              = TIME_W'(next_arr);
      end else begin
        fin = now + TIME_W'(burst_tab[best]);
        tat = fin - TIME_W'(arrival_tab[best]);
        seg.process_number = NUM_W'(best + 1);
        seg.start_time     = now;
        seg.end_time       = fin;
        seg.turnaround     = tat;
        seg.waiting        = tat - TIME_W'(burst_tab[best]);
        now                = fin;
        done[best]         = 1'b1;
        finished++;
        seg.last_segment   = (finished == jobs_loaded);
      end
      chart_q.push_back(seg);
    end
    jobs_loaded = 0;
  endtask

  task automatic take_job(input job_t j);
    // drop the word once the table is full; its last mark still counts
    if (jobs_loaded < MAX_PROCS) begin
      arrival_tab[jobs_loaded] = j.arrival_time;
      burst_tab[jobs_loaded]   = j.burst_time;
      jobs_loaded++;
    end
    if (j.last_process) build_chart();
  endtask

  task automatic check_segment(input segment_t got);
    segment_t want;
    if (chart_q.size() == 0) begin
      flag_error($sformatf("segment word with nothing expected (proc %0d, %0d..%0d)",
                           got.process_number, got.start_time, got.end_time));
    end else begin
      want = chart_q.pop_front();
      compare_field("segment_idle", got.segment_idle, want.segment_idle);
      compare_field("process_number", got.process_number, want.process_number);
      compare_field("start_time", got.start_time, want.start_time);
      compare_field("end_time", got.end_time, want.end_time);
      compare_field("turnaround", got.turnaround, want.turnaround);
      compare_field("waiting", got.waiting, want.waiting);
      compare_field("last_segment", got.last_segment, want.last_segment);
      compared++;
      if (want.segment_idle) idle_compared++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      jobs_loaded = 0;
      chart_q.delete();
      pending = 0;
    end else begin
      if (valid) check_segment(segment);
      if (start && !busy) take_job(job);
      pending = chart_q.size();
    end
  end

endmodule

// File: tb/tb_sjf_nonpreemptive_scheduler.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_sjf_nonpreemptive_scheduler
// Drives job sets into the scheduler: a directed block of ties, idle gaps,
// zero and full-range values and an overfilled table, then random sets with
// random pauses. The checker predicts and compares; this module gives the
// verdict.
// ============================================================================

module tb_sjf_nonpreemptive_scheduler;
  import sjf_pkg::*;

  localparam int ITEM_TARGET  = 380;
  localparam int QUIET_TAIL   = 60;
  localparam int DRAIN_CYCLES = 2 * (MAX_PROCS + 2) + 4;
  localparam int STALL_LIMIT  = 2000;

  typedef enum int {MIX_DENSE, MIX_SPARSE, MIX_TIES} job_mix_e;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  job_t     job = '0;
  logic     busy;
  logic     valid;
  segment_t segment;

  int errors;
  int pending;
  int compared;
  int idle_compared;
  int items_sent = 0;
  int sets_sent = 0;
  int full_sets = 0;
  int stall_cycles = 0;

  sjf_nonpreemptive_scheduler dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .job     (job),
    .valid   (valid),
    .segment (segment)
  );

  sjf_segment_checker chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .job           (job),
    .valid         (valid),
    .segment       (segment),
    .errors        (errors),
    .pending       (pending),
    .compared      (compared),
    .idle_compared (idle_compared)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // End the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("sjf_nonpreemptive_scheduler verification failed");
        $finish;
      end
    end
  end

  function automatic job_t make_job(input int arr, input int bur, input bit last);
    job_t j;
    j.arrival_time = ARR_W'(arr);
    j.burst_time   = BUR_W'(bur);
    j.last_process = last;
    return j;
  endfunction

  function automatic job_t random_job(input job_mix_e mix, input bit last);
    case (mix)
      MIX_DENSE:  return make_job($urandom_range(0, 40), $urandom_range(0, 15), last);
      MIX_SPARSE: return make_job($urandom_range(0, 65535), $urandom_range(0, 65535), last);
      default:    return make_job($urandom_range(0, 3), $urandom_range(0, 3), last);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so a back-to-back word follows without a gap.
  task automatic drive_job(input job_t j);
    start = 1'b1;
    job   = j;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic maybe_pause();
    if (items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int       set_size;
    int       pick;
    job_mix_e mix;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // lone zero-burst job at tick 0
    drive_job(make_job(0, 0, 1'b1));
    sets_sent++;
    // lone job at the extremes: long idle lead-in, full burst
    drive_job(make_job(65535, 65535, 1'b1));
    sets_sent++;
    // idle until 3, then burst and arrival ties broken by load order
    drive_job(make_job(5, 4, 1'b0));
    drive_job(make_job(5, 2, 1'b0));
    drive_job(make_job(3, 2, 1'b0));
    drive_job(make_job(5, 2, 1'b1));
    sets_sent++;
    // overfill the table: the seventeenth word is dropped but starts the run
    for (int i = 0; i <= MAX_PROCS; i++) begin
      drive_job(make_job((i == 5) ? 65535 : (i * 7) % 40,
                         (i == 3) ? 0 : (i == 9) ? 65535 : i % 5 + 1,
                         i == MAX_PROCS));
      maybe_pause();
    end
    sets_sent++;
    full_sets++;
    wait_drain();

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)      set_size = $urandom_range(1, 5);
      else if (pick < 17) set_size = $urandom_range(6, MAX_PROCS);
      else                set_size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
      mix = job_mix_e'($urandom_range(0, 2));
      for (int n = 0; n < set_size; n++) begin
        drive_job(random_job(mix, n == set_size - 1));
        maybe_pause();
      end
      sets_sent++;
      if (set_size > MAX_PROCS) full_sets++;
      // hold off now and then until the whole chart has come out
      if ($urandom_range(0, 4) == 0) wait_drain();
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d jobs in %0d sets (%0d overfilled the table)",
             items_sent, sets_sent, full_sets);
    $display("compared %0d segment words, %0d of them idle", compared, idle_compared);
    if (errors == 0) begin
      $display("sjf_nonpreemptive_scheduler verification clean");
    end else begin
      $display("sjf_nonpreemptive_scheduler verification failed");
    end
    $finish;
  end

endmodule
